FILE: design/mbus_lfr_pkg.sv
// types and constants shared by the m-bus long frame receiver files
package mbus_lfr_pkg;

  // command codes on the input channel
  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpByte  = 2'd1,
    OpTick  = 2'd2
  } opcode_e;

  // end-of-frame status codes
  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StTimeout    = 3'd1,
    StBadLen     = 3'd2,
    StTooLong    = 3'd3,
    StOverrun    = 3'd4,
    StBadHeader  = 3'd5,
    StChecksum   = 3'd6,
    StBadPayload = 3'd7
  } status_e;

  // result beat kinds
  typedef enum logic {
    KindPayload = 1'b0,
    KindEnd     = 1'b1
  } kind_e;

  localparam logic [7:0]  StartByte     = 8'h68;
  localparam logic [7:0]  MaxLen        = 8'd250;
  localparam logic [8:0]  HeadBytes     = 9'd4;
  localparam logic [8:0]  PayloadStart  = 9'd7;
  localparam logic [7:0]  MinPayloadLen = 8'd4;
  localparam logic [15:0] TimeoutReset  = 16'd1000;

endpackage

FILE: design/mbus_lfr_if.sv
// valid/ready channel interfaces for the command input and the result output

interface mbus_lfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, opcode, rx_byte, input ready);
  modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface mbus_lfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [2:0] status;
  logic [7:0] control_field;
  logic [7:0] address_field;
  logic [7:0] ci_field;
  logic [7:0] length_field;
  logic [7:0] computed_sum;

  modport source (output valid, kind, payload_byte, status, control_field, address_field,
                  ci_field, length_field, computed_sum, input ready);
  modport sink   (input valid, kind, payload_byte, status, control_field, address_field,
                  ci_field, length_field, computed_sum, output ready);
endinterface

FILE: design/mbus_lfr_rx.sv
// m-bus long frame receiver: frame tracking, checksum and result register
// Takes one command beat per clock (start, received byte or millisecond tick) and
// answers with at most one result beat in the following cycle: a data byte passed through
// (frame positions 7 and up, after C, A and CI) or a frame end carrying one of eight status
// codes. A command beat is accepted whenever the single result register is empty or
// is being drained in the same cycle, so the sustained rate is one beat per clock;
// the only limit is that result register. All per-byte work (position counter,
// length compare, mod-256 sum, timeout count) sits between the accepted beat and the
// result and state registers. There is no memory and no clearing pass after reset.
// timeout_ms is written through cfg_we_i / cfg_wdata_i and must only change while
// no frame is being received.
module mbus_lfr_rx import mbus_lfr_pkg::*; #(
  parameter int BUF_BYTES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mbus_lfr_in_if.sink          rx_in,
  mbus_lfr_out_if.source       res_out,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);

  // frame buffer limit on the 9-bit position counter
  localparam logic [8:0] BufBytes = 9'(BUF_BYTES);

  // configuration
  logic [15:0] tmo_q;

  // frame state
  logic        recv_q, recv_d;
  logic [8:0]  pos_q, pos_d;
  logic [8:0]  exp_q, exp_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] el_q, el_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  ssb_q, ssb_d;
  logic [7:0]  ctl_q, ctl_d;
  logic [7:0]  adr_q, adr_d;
  logic [7:0]  ci_q, ci_d;

  // result register
  logic        out_vld_q;
  kind_e       kind_q, res_kind;
  logic [7:0]  pbyte_q, res_pbyte;
  status_e     status_q, res_status;
  logic [7:0]  ctl_out_q, adr_out_q, ci_out_q, len_out_q, sum_out_q;

  logic        in_acc, res_vld, pass;
  logic [8:0]  pos_inc, user_end;
  logic [15:0] el_inc;
  logic [7:0]  b;

  // accept whenever the result slot is free or drains this cycle
  assign rx_in.ready = !out_vld_q || res_out.ready;
  assign in_acc      = rx_in.valid && rx_in.ready;
  assign b           = rx_in.rx_byte;
  assign pos_inc     = pos_q + 9'd1;
  assign user_end    = HeadBytes + {1'b0, len_q};
  assign el_inc      = (el_q == 16'hFFFF) ? el_q : el_q + 16'd1;

  always_comb begin
    recv_d     = recv_q;
    pos_d      = pos_q;
    exp_d      = exp_q;
    sum_d      = sum_q;
    el_d       = el_q;
    len_d      = len_q;
    ssb_d      = ssb_q;
    ctl_d      = ctl_q;
    adr_d      = adr_q;
    ci_d       = ci_q;
    res_vld    = 1'b0;
    res_kind   = KindPayload;
    res_pbyte  = 8'd0;
    res_status = StOk;
    pass       = 1'b0;

    if (in_acc) begin
      case (opcode_e'(rx_in.opcode))
        OpStart: begin
          // a start during reception is dropped
          if (!recv_q) begin
            recv_d = 1'b1;
            pos_d  = 9'd0;
            exp_d  = 9'd0;
            sum_d  = 8'd0;
            el_d   = 16'd0;
            len_d  = 8'd0;
            ssb_d  = 8'd0;
            ctl_d  = 8'd0;
            adr_d  = 8'd0;
            ci_d   = 8'd0;
          end
        end
        OpByte: begin
          if (recv_q) begin
            if (pos_q == 9'd0) begin
              // hunt for the first start byte
              if (b == StartByte) begin
                pos_d = 9'd1;
              end
            end else begin
              pos_d = pos_inc;
              if (pos_q == 9'd1) begin
                // length field: range and buffer checks end the frame at once
                len_d = b;
                exp_d = {1'b0, b} + HeadBytes + 9'd1;
                if (b == 8'd0 || b > MaxLen) begin
                  recv_d = 1'b0; res_vld = 1'b1; res_kind = KindEnd; res_status = StBadLen;
                end else if (exp_d > BufBytes) begin
                  recv_d = 1'b0; res_vld = 1'b1; res_kind = KindEnd; res_status = StTooLong;
                end
              end else begin
                if (pos_q == 9'd3) ssb_d = b;
                if (pos_q == 9'd4) ctl_d = b;
                if (pos_q == 9'd5) adr_d = b;
                if (pos_q == 9'd6) ci_d  = b;
                if (pos_q >= HeadBytes && pos_q < user_end) begin
                  sum_d = sum_q + b;
                  pass  = (pos_q >= PayloadStart);
                end
                if (exp_q != 9'd0 && pos_inc >= exp_q) begin
                  // checksum byte: frame complete
                  recv_d   = 1'b0;
                  res_vld  = 1'b1;
                  res_kind = KindEnd;
                  if (ssb_d != StartByte)      res_status = StBadHeader;
                  else if (b != sum_d)         res_status = StChecksum;
                  else if (len_q < MinPayloadLen) res_status = StBadPayload;
                  else                         res_status = StOk;
                end else if (pos_inc >= BufBytes) begin
                  recv_d = 1'b0; res_vld = 1'b1; res_kind = KindEnd; res_status = StOverrun;
                end else if (pass) begin
                  res_vld   = 1'b1;
                  res_pbyte = b;
                end
              end
            end
          end
        end
        OpTick: begin
          if (recv_q) begin
            el_d = el_inc;
            if (el_inc >= tmo_q) begin
              recv_d = 1'b0; res_vld = 1'b1; res_kind = KindEnd; res_status = StTimeout;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q  <= TimeoutReset;
      recv_q <= 1'b0;
      pos_q  <= 9'd0;
      exp_q  <= 9'd0;
      sum_q  <= 8'd0;
      el_q   <= 16'd0;
      len_q  <= 8'd0;
      ssb_q  <= 8'd0;
      ctl_q  <= 8'd0;
      adr_q  <= 8'd0;
      ci_q   <= 8'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tmo_q <= cfg_wdata_i;
      end
      recv_q <= recv_d;
      pos_q  <= pos_d;
      exp_q  <= exp_d;
      sum_q  <= sum_d;
      el_q   <= el_d;
      len_q  <= len_d;
      ssb_q  <= ssb_d;
      ctl_q  <= ctl_d;
      adr_q  <= adr_d;
      ci_q   <= ci_d;
      if (res_vld) begin
        out_vld_q <= 1'b1;
      end else if (res_out.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, captured with the frame fields as they stand after this beat
  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      kind_q    <= res_kind;
      pbyte_q   <= res_pbyte;
      status_q  <= res_status;
      ctl_out_q <= ctl_d;
      adr_out_q <= adr_d;
      ci_out_q  <= ci_d;
      len_out_q <= len_d;
      sum_out_q <= sum_d;
    end
  end

  assign res_out.valid         = out_vld_q;
  assign res_out.kind          = kind_q;
  assign res_out.payload_byte  = pbyte_q;
  assign res_out.status        = status_q;
  assign res_out.control_field = ctl_out_q;
  assign res_out.address_field = adr_out_q;
  assign res_out.ci_field      = ci_out_q;
  assign res_out.length_field  = len_out_q;
  assign res_out.computed_sum  = sum_out_q;

  // position never passes the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= BufBytes)
    else $error("byte position beyond buffer");

  // while receiving, expected total is unset or a legal frame size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !recv_q || exp_q == 9'd0 || (exp_q >= 9'd6 && exp_q <= BufBytes))
    else $error("expected total out of range");

  // start while idle opens a clean frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && rx_in.opcode == OpStart && !recv_q |=> recv_q && pos_q == 9'd0 && sum_q == 8'd0)
    else $error("start did not open a clean frame");

  // a frame-end result closes the reception
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld && res_kind == KindEnd |=> !recv_q && out_vld_q)
    else $error("frame end left reception open");

endmodule

FILE: design/mbus_long_frame_receiver.sv
// top level of the m-bus long frame receiver
// One command beat per clock is accepted whenever the single result register is
// empty or drained in the same cycle; results appear in the cycle after the command
// that causes them, so the sustained rate is one beat per clock, set by that
// result register. Commands: start, received byte, millisecond tick. Bytes before
// the first 0x68 are dropped, the length field must be 1 to 250, data bytes after
// C, A and CI are forwarded as they arrive and every reception closes with one
// frame-end beat carrying its status. No clearing pass follows reset. timeout_ms
// resets to 1000; write it via cfg_we_i / cfg_wdata_i only while idle (unenforced).
module mbus_long_frame_receiver import mbus_lfr_pkg::*; #(
  parameter int BUF_BYTES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mbus_lfr_in_if.sink     rx_in,
  mbus_lfr_out_if.source  res_out,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i
);

  // all frame tracking and the result register live in the receive core
  mbus_lfr_rx #(
    .BUF_BYTES (BUF_BYTES)
  ) u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_in       (rx_in),
    .res_out     (res_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

FILE: verif/tb_mbus_long_frame_receiver.sv
// testbench for the m-bus long frame receiver: directed table, random frames, self-checking
module tb_mbus_long_frame_receiver;
  import mbus_lfr_pkg::*;

  // buffer size, passed to the block so the predictor matches it
  localparam int BufBytes = 256;
  // opcode 3 has no enum member, the block must ignore it
  localparam logic [1:0] OpUnused = 2'd3;
  // cycles without any accepted beat before the run is declared hung
  localparam int WatchdogCycles = 4000;

  // register setting and idling for each random phase
  localparam logic [15:0] PhaseTimeout [5] = '{TimeoutReset, 16'd0, 16'hFFFF, 16'd7, 16'd1};
  localparam int PhaseSrcIdle   [5] = '{0, 63, 0, 15, 0};
  localparam int PhaseSinkStall [5] = '{0, 0, 63, 15, 0};

  // one result beat, field by field
  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload;
    status_e    status;
    logic [7:0] ctrl;
    logic [7:0] addr;
    logic [7:0] ci;
    logic [7:0] len;
    logic [7:0] csum;
  } frame_result_t;

  // one row of the directed table; lit marks a row whose outcome is written out by hand
  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    data;
    logic          lit;
    logic          lit_beat;
    frame_result_t lit_res;
  } dir_row_t;

  localparam frame_result_t NoRes = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  mbus_lfr_in_if  rx_if ();
  mbus_lfr_out_if res_if ();

  mbus_long_frame_receiver #(
    .BUF_BYTES (BufBytes)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_in       (rx_if),
    .res_out     (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // directed table
  // hand-written outcomes: anything sent while idle, the unknown opcode, noise
  // before the start byte, a start while a frame is open, and both bad length
  // extremes (zero and just above the maximum); the frame with data is left to
  // the predictor
  // ---------------------------------------------------------------------------
  dir_row_t directed_rows [21] = '{
    '{OpByte,   8'hA5,     1'b1, 1'b0, NoRes},  // byte while idle
    '{OpTick,   8'h00,     1'b1, 1'b0, NoRes},  // tick while idle
    '{OpUnused, 8'hFF,     1'b1, 1'b0, NoRes},  // unknown opcode
    '{OpStart,  8'h00,     1'b0, 1'b0, NoRes},
    '{OpByte,   8'h00,     1'b1, 1'b0, NoRes},  // noise before the start byte
    '{OpByte,   StartByte, 1'b0, 1'b0, NoRes},
    '{OpByte,   8'h00,     1'b1, 1'b1,          // length zero
      '{KindEnd, 8'h00, StBadLen, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{OpStart,  8'hFF,     1'b0, 1'b0, NoRes},
    '{OpByte,   StartByte, 1'b0, 1'b0, NoRes},
    '{OpByte,   8'hFB,     1'b1, 1'b1,          // length one above the maximum
      '{KindEnd, 8'h00, StBadLen, 8'h00, 8'h00, 8'h00, 8'hFB, 8'h00}},
    '{OpStart,  8'h00,     1'b0, 1'b0, NoRes},
    '{OpByte,   StartByte, 1'b0, 1'b0, NoRes},
    '{OpByte,   8'h04,     1'b0, 1'b0, NoRes},
    '{OpByte,   8'h04,     1'b0, 1'b0, NoRes},
    '{OpByte,   StartByte, 1'b0, 1'b0, NoRes},
    '{OpStart,  8'h00,     1'b1, 1'b0, NoRes},  // start while a frame is open
    '{OpByte,   8'hFF,     1'b0, 1'b0, NoRes},  // c
    '{OpByte,   8'h00,     1'b0, 1'b0, NoRes},  // a
    '{OpByte,   8'h80,     1'b0, 1'b0, NoRes},  // ci
    '{OpByte,   8'hFF,     1'b0, 1'b0, NoRes},  // single data byte, forwarded
    '{OpByte,   8'h7E,     1'b0, 1'b0, NoRes}   // checksum
  };

  // ---------------------------------------------------------------------------
  // predictor state: the frame being assembled and the timeout register
  // ---------------------------------------------------------------------------
  logic        m_open;
  logic [8:0]  m_pos;
  logic [8:0]  m_total;
  logic [7:0]  m_sum;
  logic [15:0] m_ms;
  logic [7:0]  m_len;
  logic [7:0]  m_hdr2;
  logic [7:0]  m_ctrl;
  logic [7:0]  m_addr;
  logic [7:0]  m_ci;
  logic [15:0] m_timeout;

  // expected result beats, oldest first
  frame_result_t pending_results [$];

  // hand-written outcome that travels with the command beat on the wire
  logic          tag_lit;
  logic          tag_lit_beat;
  frame_result_t tag_lit_res;

  int src_idle_pct;
  int sink_stall_pct;
  int useful_items;
  int err_count;
  int quiet_cycles;

  logic          in_fire;
  logic          out_fire;
  logic          made;
  logic          field_bad;
  frame_result_t seen;
  frame_result_t want;
  frame_result_t nxt;

  function automatic void clear_frame_state();
    m_open  = 1'b0;
    m_pos   = '0;
    m_total = '0;
    m_sum   = '0;
    m_ms    = '0;
    m_len   = '0;
    m_hdr2  = '0;
    m_ctrl  = '0;
    m_addr  = '0;
    m_ci    = '0;
  endfunction

  // closes the reception and builds its frame-end beat
  function automatic frame_result_t close_frame(input status_e s);
    m_open = 1'b0;
    return '{KindEnd, 8'h00, s, m_ctrl, m_addr, m_ci, m_len, m_sum};
  endfunction

  // advances the frame state by one command; returns 1 when a result beat follows
  function automatic logic predict_frame_step(input logic [1:0] op, input logic [7:0] b,
                                              output frame_result_t res);
    logic [8:0] idx;
    logic       fwd;
    res = '0;
    fwd = 1'b0;
    if (op == OpStart) begin
      if (!m_open) begin
        clear_frame_state();
        m_open = 1'b1;
      end
      return 1'b0;
    end
    if (!m_open) return 1'b0;
    if (op == OpTick) begin
      if (m_ms != 16'hFFFF) m_ms = m_ms + 16'd1;
      if (m_ms >= m_timeout) begin
        res = close_frame(StTimeout);
        return 1'b1;
      end
      return 1'b0;
    end
    if (op != OpByte) return 1'b0;
    // hunting for the first start byte
    if (m_pos == 9'd0) begin
      if (b == StartByte) m_pos = 9'd1;
      return 1'b0;
    end
    idx   = m_pos;
    m_pos = m_pos + 9'd1;
    case (idx)
      9'd1: begin
        m_len = b;
        if (b == 8'd0 || b > MaxLen) begin
          res = close_frame(StBadLen);
          return 1'b1;
        end
        m_total = {1'b0, b} + HeadBytes + 9'd1;
        if (m_total > BufBytes) begin
          res = close_frame(StTooLong);
          return 1'b1;
        end
      end
      9'd3: m_hdr2 = b;
      9'd4: m_ctrl = b;
      9'd5: m_addr = b;
      9'd6: m_ci   = b;
      default: ;
    endcase
    // user bytes c, a, ci and data feed the sum; data bytes go straight out
    if (idx >= HeadBytes && idx < HeadBytes + {1'b0, m_len}) begin
      m_sum = m_sum + b;
      fwd   = (idx >= PayloadStart);
    end
    if (m_total != 9'd0 && m_pos >= m_total) begin
      if (m_hdr2 != StartByte) res = close_frame(StBadHeader);
      else if (b != m_sum) res = close_frame(StChecksum);
      else if (m_len < MinPayloadLen) res = close_frame(StBadPayload);
      else res = close_frame(StOk);
      return 1'b1;
    end
    if (m_pos >= BufBytes) begin
      res = close_frame(StOverrun);
      return 1'b1;
    end
    if (fwd) begin
      res = '{KindPayload, b, StOk, m_ctrl, m_addr, m_ci, m_len, m_sum};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      field_bad = 1'b1;
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls at the rate of the current phase
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: result beats are checked against the oldest expectation, then the
  // command beat of the same edge runs through the predictor (a result is registered
  // and never leaves in the cycle of its command, so this order is safe)
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_fire = res_if.valid && res_if.ready;
      in_fire  = rx_if.valid && rx_if.ready;
      if (out_fire) begin
        seen = '{kind_e'(res_if.kind), res_if.payload_byte, status_e'(res_if.status),
                 res_if.control_field, res_if.address_field, res_if.ci_field,
                 res_if.length_field, res_if.computed_sum};
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: %p", $time, seen);
          err_count++;
        end else begin
          want      = pending_results.pop_front();
          field_bad = 1'b0;
          check_field("kind", 8'(want.kind), 8'(seen.kind));
          check_field("payload_byte", want.payload, seen.payload);
          check_field("status", 8'(want.status), 8'(seen.status));
          check_field("control_field", want.ctrl, seen.ctrl);
          check_field("address_field", want.addr, seen.addr);
          check_field("ci_field", want.ci, seen.ci);
          check_field("length_field", want.len, seen.len);
          check_field("computed_sum", want.csum, seen.csum);
          if (field_bad) err_count++;
        end
      end
      if (in_fire) begin
        // commands the block acts on, as opposed to ones it drops
        if ((rx_if.opcode == OpStart && !m_open) ||
            (m_open && (rx_if.opcode == OpByte || rx_if.opcode == OpTick)))
          useful_items++;
        made = predict_frame_step(rx_if.opcode, rx_if.rx_byte, nxt);
        if (tag_lit) begin
          if (tag_lit_beat) pending_results.push_back(tag_lit_res);
        end else if (made) begin
          pending_results.push_back(nxt);
        end
      end
      if (cfg_we_i) m_timeout = cfg_wdata_i;
      // watchdog on accepted beats in either direction
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogCycles) begin
          $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // drives one command beat and returns at the edge that accepts it; valid stays
  // high into the next beat unless a gap is drawn
  task automatic send_beat(input logic [1:0] op, input logic [7:0] b,
                           input logic lit = 1'b0, input logic lit_beat = 1'b0,
                           input frame_result_t lit_res = '0);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.opcode  <= op;
    rx_if.rx_byte <= b;
    tag_lit       <= lit;
    tag_lit_beat  <= lit_beat;
    tag_lit_res   <= lit_res;
    do @(posedge clk_i); while (!(rx_if.valid && rx_if.ready));
  endtask

  // one reception: mostly well-formed frames with random content, sometimes a bad
  // length, a corrupted second start byte or checksum, with ticks and stray starts
  task automatic send_frame();
    logic [7:0] len;
    logic [7:0] acc;
    logic [7:0] b;
    logic [7:0] body [$];
    int         pick;
    send_beat(OpStart, 8'($urandom_range(0, 255)));
    // noise ahead of the start byte
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom_range(0, 255));
      if (b == StartByte) b = 8'h00;
      send_beat(OpByte, b);
    end
    send_beat(OpByte, StartByte);
    // mostly short frames, a few long ones, a few bad lengths
    pick = $urandom_range(99);
    if (pick < 4) len = ($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(251, 255));
    else if (pick < 7) len = (pick == 4) ? MaxLen : 8'($urandom_range(17, 249));
    else len = 8'($urandom_range(1, 16));
    body.push_back(len);
    if (len != 8'd0 && len <= MaxLen) begin
      // the repeated length is not checked by the block
      body.push_back(($urandom_range(99) < 5) ? 8'($urandom_range(0, 255)) : len);
      b = StartByte;
      if ($urandom_range(99) < 8) b = StartByte ^ 8'($urandom_range(1, 255));
      body.push_back(b);
      acc = 8'h00;
      repeat (len) begin
        b   = 8'($urandom_range(0, 255));
        acc = acc + b;
        body.push_back(b);
      end
      if ($urandom_range(99) < 10) acc = acc ^ 8'($urandom_range(1, 255));
      body.push_back(acc);
    end
    foreach (body[i]) begin
      if ($urandom_range(99) < 6) send_beat(OpTick, 8'($urandom_range(0, 255)));
      if ($urandom_range(99) < 2) repeat ($urandom_range(1, 12)) send_beat(OpTick, 8'h00);
      if ($urandom_range(99) < 2) send_beat(OpStart, 8'h00);
      send_beat(OpByte, body[i]);
    end
  endtask

  // short burst of arbitrary commands, the unused opcode included
  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // sender holds off until every expected beat is back, then idles on for a command
  // still in flight
  task automatic drain_results();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int target;
    rst_ni         <= 1'b0;
    rx_if.valid    <= 1'b0;
    rx_if.opcode   <= OpStart;
    rx_if.rx_byte  <= 8'h00;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= 16'h0000;
    tag_lit        <= 1'b0;
    tag_lit_beat   <= 1'b0;
    tag_lit_res    <= '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    useful_items   = 0;
    err_count      = 0;
    quiet_cycles   = 0;
    clear_frame_state();
    m_timeout = TimeoutReset;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, with the register at its reset value
    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].data, directed_rows[i].lit,
                directed_rows[i].lit_beat, directed_rows[i].lit_res);

    // random phases; the register changes only with nothing in flight
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain_results();
        write_timeout(PhaseTimeout[p]);
      end
      src_idle_pct   = PhaseSrcIdle[p];
      sink_stall_pct = PhaseSinkStall[p];
      target = useful_items + ((p == 0) ? 130 : 120);
      while (useful_items < target) begin
        if ($urandom_range(99) < 80) send_frame();
        else send_noise();
      end
    end

    drain_results();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mbus_lfr_pkg.sv
design/mbus_lfr_if.sv
design/mbus_lfr_rx.sv
design/mbus_long_frame_receiver.sv
verif/tb_mbus_long_frame_receiver.sv
